// File: hdl/ffaa_pkg.sv
package ffaa_pkg;
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_RESET = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OOM      = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [31:0] ARENA_SIZE_RST = 32'd65536;

	typedef struct packed {
		logic [31:0] largest;
		logic [31:0] allocated;
		logic [31:0] unallocated;
		logic [31:0] fragmented;
		logic [31:0] unusable;
	} stats_t;
endpackage

// File: hdl/ffaa_gap_acc.sv
module ffaa_gap_acc import ffaa_pkg::*; #(
	parameter int BLOCK_HDR_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clr,
	input  logic        add_en,
	input  logic [33:0] gap,
	input  logic        inner,
	input  logic [31:0] length,
	input  logic        len_en,
	output stats_t      stats
);
	localparam logic [33:0] HDR = 34'(BLOCK_HDR_BYTES);
	logic [33:0] largest_q, alloc_q, unalloc_q, frag_q, unuse_q;
	logic        usable;
	logic [33:0] avail;

	assign usable = gap > HDR;
	assign avail = usable ? gap - HDR : '0;

	function automatic logic [33:0] sadd(input logic [33:0] a, input logic [33:0] b);
		logic [34:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > 35'h0FFFFFFFF) ? 34'h0FFFFFFFF : s[33:0];
	endfunction

	function automatic logic [31:0] sat(input logic [33:0] v);
		return (v > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			largest_q <= '0;
			alloc_q <= '0;
			unalloc_q <= '0;
			frag_q <= '0;
			unuse_q <= '0;
		end else if (clr) begin
			largest_q <= '0;
			alloc_q <= '0;
			unalloc_q <= '0;
			frag_q <= '0;
			unuse_q <= '0;
		end else begin
			if (add_en) begin
				unalloc_q <= sadd(unalloc_q, avail);
				if (!usable)
					unuse_q <= sadd(unuse_q, gap);
				else if (inner)
					frag_q <= sadd(frag_q, avail);
				if (avail > largest_q)
					largest_q <= avail;
			end
			if (len_en)
				alloc_q <= sadd(alloc_q, {2'b0, length});
		end
	end

	assign stats.largest = sat(largest_q);
	assign stats.allocated = sat(alloc_q);
	assign stats.unallocated = sat(unalloc_q);
	assign stats.fragmented = sat(frag_q);
	assign stats.unusable = sat(unuse_q);
endmodule

// File: hdl/first_fit_arena_allocator.sv
// the table is walked one entry per cycle; an allocate first reads the last entry to try an
// append, walks the table for the fit only if that fails, then does the insert shift; a free
// walks for match and remove shift; then one statistics pass over all entries; one request at a time
// is accepted, only in idle after the previous result is taken; walks use the single table read port
// reset clears the block count and sets arena_size to 65536; table contents stay
module first_fit_arena_allocator import ffaa_pkg::*; #(
	parameter int MAX_BLOCKS      = 64,
	parameter int BLOCK_HDR_BYTES = 32,
	parameter int ARENA_HDR_BYTES = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // operation, request_size, free_address
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,   // allocated_address, largest_free, total_allocated,
	                                // total_unallocated, total_fragmented, total_unusable
	output logic [1:0]   m_tuser    // status
);
	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
	localparam logic [33:0] HDR = 34'(BLOCK_HDR_BYTES);
	localparam logic [33:0] AHDR = 34'(ARENA_HDR_BYTES);

	localparam logic [3:0] S_IDLE = 4'd0, S_AREAD = 4'd1, S_APPEND = 4'd2,
		S_FIT = 4'd3, S_INS = 4'd4, S_FREE = 4'd5, S_DEL = 4'd6,
		S_STAT = 4'd7, S_OUT = 4'd8, S_WAIT = 4'd9;

	logic [3:0]    state_q;
	logic [31:0]   arena_q;
	logic [CW-1:0] count_q, idx_q;
	logic [1:0]    status_q;
	logic [31:0]   size_q, faddr_q, addr_q, ins_off_q;
	logic [33:0]   point_q;
	logic          rd_valid_q;
	logic [IW-1:0] rd_idx_q;

	logic [31:0] off_mem [MAX_BLOCKS];
	logic [31:0] len_mem [MAX_BLOCKS];
	logic [31:0] rd_off_q, rd_len_q;

	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [31:0]   wr_off, wr_len;

	logic          acc_clr, acc_add, acc_inner, acc_len;
	logic [33:0]   acc_gap;
	stats_t        stats;
	stats_t        stats_q;

	logic [33:0] need, rd_end, arena34, gap_c;
	logic        fit_hit;
	assign need = {2'b0, size_q} + HDR;
	assign rd_end = {2'b0, rd_off_q} + HDR + {2'b0, rd_len_q};
	assign arena34 = {2'b0, arena_q};
	assign fit_hit = rd_valid_q && {2'b0, rd_off_q} > point_q &&
		{2'b0, rd_off_q} - point_q >= need;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			off_mem[wr_addr] <= wr_off;
			len_mem[wr_addr] <= wr_len;
		end
		if (rd_en) begin
			rd_off_q <= off_mem[rd_addr];
			rd_len_q <= len_mem[rd_addr];
		end
	end

	ffaa_gap_acc #(.BLOCK_HDR_BYTES(BLOCK_HDR_BYTES)) u_acc (
		.clk(clk), .arst_n(arst_n), .clr(acc_clr), .add_en(acc_add), .gap(acc_gap),
		.inner(acc_inner), .length(rd_len_q), .len_en(acc_len), .stats(stats)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_WAIT);
	assign m_tuser = status_q;
	assign m_tdata = {stats_q.unusable, stats_q.fragmented, stats_q.unallocated,
		stats_q.allocated, stats_q.largest, addr_q};

	// sequencer: rd_idx_q is the entry whose data shows on rd_*_q this cycle
	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q[IW-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[IW-1:0];
		wr_off = rd_off_q;
		wr_len = rd_len_q;
		acc_clr = 1'b0;
		acc_add = 1'b0;
		acc_inner = 1'b0;
		acc_len = 1'b0;
		acc_gap = '0;
		gap_c = '0;
		unique case (state_q)
			S_AREAD, S_FIT, S_FREE, S_STAT: begin
				rd_en = (idx_q < count_q) && !(state_q == S_FIT && fit_hit);
				if (state_q == S_STAT && rd_valid_q) begin
					gap_c = ({2'b0, rd_off_q} > point_q) ? {2'b0, rd_off_q} - point_q : '0;
					acc_gap = gap_c;
					acc_add = 1'b1;
					acc_inner = 1'b1;
					acc_len = 1'b1;
				end else if (state_q == S_STAT && idx_q >= count_q) begin
					acc_gap = (arena34 > point_q) ? arena34 - point_q : '0;
					acc_add = 1'b1;
				end
			end
			S_INS: begin
				// idx_q is one past the next source entry; a source moves up by one
				rd_en = (idx_q > ins_off_q[CW-1:0]);
				rd_addr = IW'(idx_q - CW'(1));
				if (rd_valid_q) begin
					wr_en = 1'b1;
					wr_addr = IW'(rd_idx_q + IW'(1));
				end else if (idx_q == ins_off_q[CW-1:0]) begin
					wr_en = 1'b1;
					wr_off = point_q[31:0];
					wr_len = size_q;
				end
			end
			S_DEL: begin
				rd_en = (idx_q < count_q);
				if (rd_valid_q) begin
					wr_en = 1'b1;
					wr_addr = IW'(rd_idx_q - IW'(1));
				end
			end
			S_IDLE: acc_clr = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			arena_q <= ARENA_SIZE_RST;
			count_q <= '0;
			idx_q <= '0;
			rd_valid_q <= 1'b0;
			rd_idx_q <= '0;
			status_q <= ST_OK;
			size_q <= '0;
			faddr_q <= '0;
			addr_q <= '0;
			point_q <= '0;
			ins_off_q <= '0;
			stats_q <= '0;
		end else begin
			if (cfg_we)
				arena_q <= cfg_wdata;
			rd_valid_q <= rd_en;
			rd_idx_q <= rd_addr;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						size_q <= s_tdata[33:2];
						faddr_q <= s_tdata[65:34];
						status_q <= ST_OK;
						addr_q <= '0;
						idx_q <= '0;
						point_q <= AHDR;
						priority case (s_tdata[1:0])
							OP_ALLOC: begin
								if (count_q >= MAXC) begin
									status_q <= ST_FULL;
									state_q <= S_STAT;
								end else if (count_q == '0) begin
									state_q <= S_APPEND;
								end else begin
									idx_q <= count_q - CW'(1);
									state_q <= S_AREAD;
								end
							end
							OP_FREE: state_q <= S_FREE;
							OP_RESET: begin
								count_q <= '0;
								state_q <= S_STAT;
							end
							default: state_q <= S_STAT;
						endcase
					end
				end
				S_AREAD: begin
					idx_q <= count_q;
					state_q <= S_APPEND;
				end
				S_APPEND: begin
					// point of append: end of last block or arena header
					if (((count_q == '0) ? AHDR : rd_end) < arena34 &&
						arena34 - ((count_q == '0) ? AHDR : rd_end) >= need) begin
						point_q <= (count_q == '0) ? AHDR : rd_end;
						ins_off_q <= 32'(count_q);
						idx_q <= count_q;
						state_q <= S_INS;
					end else begin
						point_q <= AHDR;
						idx_q <= '0;
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					if (rd_valid_q) begin
						if (fit_hit) begin
							ins_off_q <= 32'(rd_idx_q);
							idx_q <= count_q;
							state_q <= S_INS;
						end else begin
							point_q <= rd_end;
							idx_q <= idx_q + CW'(1);
						end
					end else if (idx_q >= count_q) begin
						if (arena34 > point_q && arena34 - point_q >= need) begin
							ins_off_q <= 32'(count_q);
							idx_q <= count_q;
							state_q <= S_INS;
						end else begin
							status_q <= ST_OOM;
							idx_q <= '0;
							point_q <= AHDR;
							state_q <= S_STAT;
						end
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_INS: begin
					// shift entries up from the top, then write the new entry
					if (!rd_valid_q && idx_q == ins_off_q[CW-1:0]) begin
						addr_q <= point_q[31:0] + 32'(BLOCK_HDR_BYTES);
						count_q <= count_q + CW'(1);
						idx_q <= '0;
						point_q <= AHDR;
						state_q <= S_STAT;
					end else if (idx_q > ins_off_q[CW-1:0]) begin
						idx_q <= idx_q - CW'(1);
					end
				end
				S_FREE: begin
					if (rd_valid_q) begin
						if ({2'b0, rd_off_q} + HDR == {2'b0, faddr_q}) begin
							idx_q <= CW'(rd_idx_q) + CW'(1);
							state_q <= S_DEL;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end else if (idx_q >= count_q) begin
						status_q <= ST_NOTFOUND;
						idx_q <= '0;
						state_q <= S_STAT;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DEL: begin
					if (idx_q >= count_q && !rd_valid_q && !rd_en) begin
						count_q <= count_q - CW'(1);
						idx_q <= '0;
						point_q <= AHDR;
						state_q <= S_STAT;
					end else if (idx_q < count_q) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_STAT: begin
					if (rd_valid_q) begin
						point_q <= rd_end;
						idx_q <= idx_q + CW'(1);
					end else if (idx_q >= count_q) begin
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_OUT: begin
					stats_q <= stats;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (m_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= MAXC)
		else $error("block count above table depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[31:0] == 32'd0)
		else $error("address on failed request");
endmodule

// File: verif/ffaa_checker.sv
`timescale 1ns / 1ps

module ffaa_checker import ffaa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [71:0]  s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,
	input  logic [1:0]   m_tuser,
	output int           errors,
	output int           pending
);
	localparam int MAX_BLOCKS      = 64;
	localparam longint unsigned BLOCK_HDR = 32;
	localparam longint unsigned ARENA_HDR = 24;
	localparam longint unsigned SAT = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] addr;
		stats_t      stats;
	} alloc_result_t;

	logic [31:0] blk_offset [MAX_BLOCKS];
	logic [31:0] blk_length [MAX_BLOCKS];
	int          blk_count;
	logic [31:0] arena_bytes;
	alloc_result_t expected_q [$];

	assign pending = expected_q.size();

	function automatic longint unsigned gap_len(longint unsigned from, longint unsigned to);
		return (to > from) ? to - from : 0;
	endfunction

	function automatic longint unsigned blk_end(int i);
		return longint'(blk_offset[i]) + BLOCK_HDR + longint'(blk_length[i]);
	endfunction

	function automatic void insert_block(int idx, longint unsigned hdr, longint unsigned size);
		for (int i = blk_count; i > idx; i--) begin
			blk_offset[i] = blk_offset[i-1];
			blk_length[i] = blk_length[i-1];
		end
		blk_offset[idx] = hdr[31:0];
		blk_length[idx] = size[31:0];
		blk_count++;
	endfunction

	function automatic logic [31:0] sat32(longint unsigned v);
		return (v > SAT) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic alloc_result_t serve_request(logic [1:0] op, logic [31:0] size,
			logic [31:0] faddr);
		alloc_result_t r;
		longint unsigned need, point, lim, g, avail;
		longint unsigned st [5];
		bit done;
		r = '0;
		r.status = ST_OK;
		if (op == OP_ALLOC) begin
			need = longint'(size) + BLOCK_HDR;
			done = 0;
			if (blk_count >= MAX_BLOCKS) begin
				r.status = ST_FULL;
				done = 1;
			end
			if (!done) begin
				point = blk_count ? blk_end(blk_count - 1) : ARENA_HDR;
				if (gap_len(point, arena_bytes) >= need) begin
					insert_block(blk_count, point, size);
					r.addr = 32'(point + BLOCK_HDR);
					done = 1;
				end
			end
			if (!done) begin
				point = ARENA_HDR;
				for (int i = 0; i <= blk_count && !done; i++) begin
					lim = (i < blk_count) ? longint'(blk_offset[i]) : longint'(arena_bytes);
					if (gap_len(point, lim) >= need) begin
						insert_block(i, point, size);
						r.addr = 32'(point + BLOCK_HDR);
						done = 1;
					end else if (i < blk_count)
						point = blk_end(i);
				end
				if (!done)
					r.status = ST_OOM;
			end
		end else if (op == OP_FREE) begin
			r.status = ST_NOTFOUND;
			for (int i = 0; i < blk_count; i++) begin
				if (longint'(blk_offset[i]) + BLOCK_HDR == longint'(faddr)) begin
					for (int j = i; j + 1 < blk_count; j++) begin
						blk_offset[j] = blk_offset[j+1];
						blk_length[j] = blk_length[j+1];
					end
					blk_count--;
					r.status = ST_OK;
					break;
				end
			end
		end else if (op == OP_RESET)
			blk_count = 0;

		// largest, allocated, unallocated, fragmented, unusable
		foreach (st[k]) st[k] = 0;
		point = ARENA_HDR;
		for (int i = 0; i <= blk_count; i++) begin
			lim = (i < blk_count) ? longint'(blk_offset[i]) : longint'(arena_bytes);
			g = gap_len(point, lim);
			avail = (g < BLOCK_HDR + 1) ? 0 : g - BLOCK_HDR;
			st[2] += avail;
			if (g < BLOCK_HDR + 1)
				st[4] += g;
			else if (i < blk_count)
				st[3] += avail;
			if (avail > st[0])
				st[0] = avail;
			if (i < blk_count) begin
				st[1] += longint'(blk_length[i]);
				point = blk_end(i);
			end
		end
		r.stats.largest     = sat32(st[0]);
		r.stats.allocated   = sat32(st[1]);
		r.stats.unallocated = sat32(st[2]);
		r.stats.fragmented  = sat32(st[3]);
		r.stats.unusable    = sat32(st[4]);
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t e;
		if (!arst_n) begin
			blk_count = 0;
			arena_bytes = ARENA_SIZE_RST;
			expected_q.delete();
		end else begin
			if (cfg_we)
				arena_bytes = cfg_wdata;
			if (s_tvalid && s_tready)
				expected_q.push_back(serve_request(s_tdata[1:0], s_tdata[33:2],
					s_tdata[65:34]));
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with no request outstanding");
					errors++;
				end else begin
					e = expected_q.pop_front();
					compare_field("status", 32'(e.status), 32'(m_tuser));
					compare_field("allocated_address", e.addr, m_tdata[31:0]);
					compare_field("largest_free", e.stats.largest, m_tdata[63:32]);
					compare_field("total_allocated", e.stats.allocated, m_tdata[95:64]);
					compare_field("total_unallocated", e.stats.unallocated, m_tdata[127:96]);
					compare_field("total_fragmented", e.stats.fragmented, m_tdata[159:128]);
					compare_field("total_unusable", e.stats.unusable, m_tdata[191:160]);
				end
			end
		end
	end
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ffaa_pkg::*;

	localparam int LATENCY = 3 * 64 + 10;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [31:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;
	logic [1:0]   m_tuser;
	int           errors;
	int           pending;

	int           send_idle;
	int           recv_idle;
	bit           hold_req;
	int           cycles;
	logic [31:0]  live_addrs [$];
	logic [31:0]  cur_arena;

	first_fit_arena_allocator uut (.*);

	ffaa_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// remember granted addresses so frees can target real blocks
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready && m_tuser == ST_OK && m_tdata[31:0] != 0)
			live_addrs.push_back(m_tdata[31:0]);

	initial begin
		int hold_cnt;
		bit held;
		hold_cnt = 0;
		held = 0;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (!hold_req)
				held = 0;
			else if (!held) begin
				hold_cnt = 700;
				held = 1;
			end
			if (hold_cnt > 0) begin
				m_tready = 0;
				hold_cnt--;
			end else
				m_tready = arst_n && ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic send_request(logic [1:0] op, logic [31:0] size, logic [31:0] faddr);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = {6'b0, faddr, size, op};
		#1;
		while (!s_tready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic write_arena(logic [31:0] v);
		wait (pending == 0);
		repeat (LATENCY) @(negedge clk);
		cfg_we = 1;
		cfg_wdata = v;
		cur_arena = v;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic random_request(int alloc_pct, int size_max);
		int r, sel;
		logic [31:0] size, faddr;
		r = $urandom_range(0, 99);
		sel = $urandom_range(0, 99);
		if (sel < 70)
			size = $urandom_range(0, size_max);
		else if (sel < 85)
			size = $urandom_range(0, 4 * size_max);
		else if (sel < 95)
			size = $urandom;
		else
			case ($urandom_range(0, 3))
				0: size = 0;
				1: size = 32'hFFFF_FFFF;
				2: size = cur_arena - 56;
				default: size = cur_arena - 57;
			endcase
		faddr = $urandom;
		if (r < alloc_pct)
			send_request(OP_ALLOC, size, faddr);
		else if (r < 94) begin
			if (live_addrs.size() > 0 && $urandom_range(0, 99) < 75) begin
				sel = $urandom_range(0, live_addrs.size() - 1);
				faddr = live_addrs[sel];
				live_addrs.delete(sel);
			end else if (live_addrs.size() > 0 && $urandom_range(0, 1))
				faddr = live_addrs[0] + 1;
			send_request(OP_FREE, size, faddr);
		end else if (r < 97) begin
			live_addrs.delete();
			send_request(OP_RESET, size, faddr);
		end else
			send_request(OP_UNUSED, size, faddr);
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		s_tvalid = 0;
		s_tdata = '0;
		hold_req = 0;
		send_idle = 13;
		recv_idle = 88;
		cur_arena = ARENA_SIZE_RST;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, 1, 32'hFFFF_FFFF);
		send_request(OP_ALLOC, 32'hFFFF_FFFF, 0);
		send_request(OP_ALLOC, 65536 - 200, 0);
		send_request(OP_FREE, 0, 56);
		send_request(OP_FREE, 0, 56);
		send_request(OP_FREE, 0, 0);
		send_request(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_UNUSED, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		send_request(OP_ALLOC, 100, 0);
		send_request(OP_ALLOC, 100, 0);
		send_request(OP_ALLOC, 100, 0);
		send_request(OP_FREE, 0, 56 + 33 + 132);
		send_request(OP_ALLOC, 10, 0);
		send_request(OP_ALLOC, 65000, 0);
		send_request(OP_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		live_addrs.delete();

		// receiver backs off while requests keep coming
		hold_req = 1;
		repeat (20) random_request(60, 1500);
		hold_req = 0;
		repeat (130) random_request(60, 1500);

		write_arena(57);
		send_request(OP_ALLOC, 1, 0);
		send_request(OP_ALLOC, 0, 0);
		repeat (50) random_request(60, 2);

		write_arena(32'hFFFF_FFFF);
		send_idle = 88;
		recv_idle = 13;
		repeat (150) random_request(65, 32'h0FFF_FFFF);

		// shrink under existing blocks
		write_arena(3000);
		repeat (80) random_request(55, 200);

		send_idle = 0;
		recv_idle = 0;
		write_arena(ARENA_SIZE_RST);
		repeat (100) random_request(85, 40);
		wait (pending == 0);
		@(negedge clk);
		repeat (120) random_request(55, 800);

		wait (pending == 0);
		repeat (LATENCY) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// File: files.f
hdl/ffaa_pkg.sv
hdl/ffaa_gap_acc.sv
hdl/first_fit_arena_allocator.sv
verif/ffaa_checker.sv
verif/tb_top.sv
